### hdl/bgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg
// Types, constants and codes shared by the gradient clipping block.
// ----------------------------------------------------------------------------
package bgc_pkg;

  // gradient store
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // fixed point constants (Q1.15)
  localparam logic [15:0] PROB_FLOOR = 16'd328;
  localparam logic [16:0] ONE_Q15    = 17'd32768;

  // divider geometry: quotient is known to stay below 2^31
  localparam int NUM_W     = 65;
  localparam int DEN_W     = 48;
  localparam int QUOT_W    = 31;
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT  = 1'b1;

  // input transaction
  typedef struct packed {
    logic               cmd;
    logic [15:0]        label;
    logic [15:0]        prob;
    logic signed [31:0] weight;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] gradient;
    logic               last;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic        cmd;
    logic [15:0] label;
    logic [15:0] p;
    logic [15:0] q;
    logic [31:0] absw;
    logic        wneg;
  } fe_item_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // divider result
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

### hdl/bgc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### hdl/bgc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_front
// Accepts transactions, clamps the prediction and prepares the weight.
// ----------------------------------------------------------------------------
module bgc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bgc_pkg::in_item_t in_data,
  input  bgc_pkg::q_stat_t  q_stat,
  output logic              push,
  output bgc_pkg::fe_item_t push_data
);

  logic               fr_valid_r, fr_valid_nxt;
  bgc_pkg::fe_item_t  fr_item_r, fr_item_nxt;
  logic               accept;

  assign busy      = fr_valid_r & q_stat.full;
  assign accept    = start & ~busy;
  assign push      = fr_valid_r & ~q_stat.full;
  assign push_data = fr_item_r;

  // clamp p and q at 0.01, magnitude of the weight
  always_comb begin
    fr_item_nxt       = fr_item_r;
    fr_item_nxt.cmd   = in_data.cmd;
    fr_item_nxt.label = in_data.label;
    fr_item_nxt.p     = (in_data.prob < bgc_pkg::PROB_FLOOR) ? bgc_pkg::PROB_FLOOR
                                                             : in_data.prob;
    // q = 1 - prob, floored; prob above 1.0 also lands on the floor
    if ({1'b0, in_data.prob} + {1'b0, bgc_pkg::PROB_FLOOR} > bgc_pkg::ONE_Q15) begin
      fr_item_nxt.q = bgc_pkg::PROB_FLOOR;
    end else begin
      fr_item_nxt.q = 16'(bgc_pkg::ONE_Q15 - {1'b0, in_data.prob});
    end
    fr_item_nxt.wneg = in_data.weight[31];
    fr_item_nxt.absw = in_data.weight[31] ? 32'(0 - in_data.weight) : in_data.weight;
    if (!accept) begin
      fr_item_nxt = fr_item_r;
    end
    fr_valid_nxt = accept | (fr_valid_r & q_stat.full);
  end

  // holding stage
  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

endmodule

### hdl/bgc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_queue
// Two entry queue between front and back.
// ----------------------------------------------------------------------------
module bgc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bgc_pkg::fe_item_t push_data,
  input  logic              pop,
  output bgc_pkg::fe_item_t head,
  output bgc_pkg::q_stat_t  q_stat
);

  bgc_pkg::fe_item_t mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hdl/bgc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_divider
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
module bgc_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bgc_pkg::NUM_W-1:0]   num,
  input  logic [bgc_pkg::DEN_W-1:0]   den,
  output bgc_pkg::div_res_t           res
);

  logic [bgc_pkg::DEN_W:0]    rem_r, rem_nxt;
  logic [bgc_pkg::QUOT_W-1:0] nl_r, nl_nxt;
  logic [bgc_pkg::QUOT_W-1:0] q_r, q_nxt;
  logic [bgc_pkg::DEN_W-1:0]  den_r, den_nxt;
  logic [bgc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [bgc_pkg::DEN_W:0]    trial;

  assign res.done = done_r;
  assign res.quot = q_r;

  // one shift, compare and subtract per cycle
  always_comb begin
    rem_nxt  = rem_r;
    nl_nxt   = nl_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[bgc_pkg::DEN_W-1:0], nl_r[bgc_pkg::QUOT_W-1]};
    if (start) begin
      rem_nxt  = (bgc_pkg::DEN_W + 1)'(num[bgc_pkg::NUM_W-1:bgc_pkg::QUOT_W]);
      nl_nxt   = num[bgc_pkg::QUOT_W-1:0];
      den_nxt  = den;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      nl_nxt = {nl_r[bgc_pkg::QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[bgc_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[bgc_pkg::QUOT_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == bgc_pkg::STEP_W'(bgc_pkg::DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    nl_r   <= nl_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

### hdl/bgc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_back
// Executes queued transactions: gradient arithmetic, store, clipped reads.
// ----------------------------------------------------------------------------
module bgc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bgc_pkg::q_stat_t           q_stat,
  input  bgc_pkg::fe_item_t          head,
  output logic                       pop,
  input  logic [15:0]                batch_count,
  input  logic [30:0]                clip_limit,
  output logic                       out_valid,
  output bgc_pkg::out_item_t         out_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_CHK, ST_LDIV, ST_LWR,
    ST_RD1, ST_CST, ST_CDIV, ST_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  bgc_pkg::fe_item_t            ent_r, ent_nxt;
  logic [31:0]                  xq_r, xq_nxt;
  logic signed [34:0]           ymp_r, ymp_nxt;
  logic [31:0]                  pq_r, pq_nxt;
  logic [bgc_pkg::DEN_W-1:0]    den_r, den_nxt;
  logic [32:0]                  absdiff_r, absdiff_nxt;
  logic                         dneg_r, dneg_nxt;
  logic [63:0]                  prod_r, prod_nxt;
  logic [bgc_pkg::NUM_W-1:0]    num_r, num_nxt;
  logic                         sat_r, sat_nxt;
  logic                         clip_r, clip_nxt;
  logic                         neg_r, neg_nxt;
  logic [31:0]                  g_r, g_nxt;
  logic [bgc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [bgc_pkg::CNT_W-1:0]    rd_r, rd_nxt;
  logic [31:0]                  max_r, max_nxt;
  logic                         done_r, done_nxt;
  logic                         ov_r, ov_nxt;
  bgc_pkg::out_item_t           od_r, od_nxt;
  logic                         cdiv_go_r;

  logic                         div_start;
  bgc_pkg::div_res_t            div_res;
  logic                         ram_we, ram_re;
  logic [31:0]                  ram_wdata, ram_rdata;
  logic [15:0]                  n_eff;
  logic [bgc_pkg::CNT_W-1:0]    cnt_eff;
  logic signed [35:0]           diff;
  logic [31:0]                  mag, gval, mval, rd_mag;
  logic                         neg;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign n_eff     = (batch_count == 16'd0) ? 16'd1 : batch_count;

  bgc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .res   (div_res)
  );

  bgc_ram #(
    .WIDTH (32),
    .DEPTH (bgc_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[bgc_pkg::ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_r[bgc_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    xq_nxt      = xq_r;
    ymp_nxt     = ymp_r;
    pq_nxt      = pq_r;
    den_nxt     = den_r;
    absdiff_nxt = absdiff_r;
    dneg_nxt    = dneg_r;
    prod_nxt    = prod_r;
    num_nxt     = num_r;
    sat_nxt     = sat_r;
    clip_nxt    = clip_r;
    neg_nxt     = neg_r;
    g_nxt       = g_r;
    cnt_nxt     = cnt_r;
    rd_nxt      = rd_r;
    max_nxt     = max_r;
    done_nxt    = done_r;
    ov_nxt      = 1'b0;
    od_nxt      = od_r;
    pop         = 1'b0;
    div_start   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    cnt_eff     = done_r ? '0 : cnt_r;
    diff        = 36'(signed'({4'b0, xq_r})) - 36'(ymp_r);
    // signed result of a load, saturated to 32 bits
    neg         = ~(ent_r.wneg ^ dneg_r);
    mag         = sat_r ? 32'h8000_0000 : {1'b0, div_res.quot};
    gval        = neg ? (32'd0 - mag) : (sat_r ? 32'h7FFF_FFFF : mag);
    mval        = neg ? mag : gval;
    rd_mag      = ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          ent_nxt = head;
          if (head.cmd == bgc_pkg::CMD_LOAD) begin
            // a load after the final read opens a new batch
            if (done_r) begin
              cnt_nxt  = '0;
              rd_nxt   = '0;
              max_nxt  = '0;
              done_nxt = 1'b0;
            end
            if (cnt_eff < bgc_pkg::CNT_W'(bgc_pkg::STORE_DEPTH)) begin
              state_nxt = ST_MUL1;
            end
          end else if (rd_r < cnt_r) begin
            ram_re    = 1'b1;
            state_nxt = ST_RD1;
          end
        end
      end
      // x*q, (1-x)*p and p*q
      ST_MUL1: begin
        xq_nxt    = ent_r.label * ent_r.q;
        ymp_nxt   = 35'((18'sd32768 - signed'({2'b0, ent_r.label}))
                        * signed'({1'b0, ent_r.p}));
        pq_nxt    = ent_r.p * ent_r.q;
        state_nxt = ST_MUL2;
      end
      // numerator difference and denominator p*q*N
      ST_MUL2: begin
        dneg_nxt    = diff[35];
        absdiff_nxt = diff[35] ? 33'(-diff) : diff[32:0];
        den_nxt     = pq_r * n_eff;
        state_nxt   = ST_MUL3;
      end
      ST_MUL3: begin
        prod_nxt  = ent_r.absw * absdiff_r[31:0];
        state_nxt = ST_MUL4;
      end
      // top bit of |diff| adds |w| << 32
      ST_MUL4: begin
        num_nxt   = {1'b0, prod_r}
                    + (absdiff_r[32] ? {1'b0, ent_r.absw, 32'd0} : '0);
        state_nxt = ST_CHK;
      end
      // quotient at or above 2^31 saturates without dividing
      ST_CHK: begin
        sat_nxt = ({14'd0, num_r} >= {den_r, 31'd0});
        if ({14'd0, num_r} >= {den_r, 31'd0}) begin
          state_nxt = ST_LWR;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (div_res.done) begin
          state_nxt = ST_LWR;
        end
      end
      // store and track largest magnitude
      ST_LWR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (mval > max_r) begin
          max_nxt = mval;
        end
        state_nxt = ST_IDLE;
      end
      // stored gradient available, decide on clipping
      ST_RD1: begin
        g_nxt    = ram_rdata;
        neg_nxt  = ram_rdata[31];
        clip_nxt = (clip_limit != 31'd0) && (max_r > {1'b0, clip_limit});
        prod_nxt = rd_mag * {1'b0, clip_limit};
        if ((clip_limit != 31'd0) && (max_r > {1'b0, clip_limit})) begin
          state_nxt = ST_CST;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_CST: begin
        num_nxt   = {1'b0, prod_r};
        den_nxt   = {16'd0, max_r};
        state_nxt = ST_CDIV;
      end
      // divider started on entry to this state, operands now registered
      ST_CDIV: begin
        div_start = cdiv_go_r;
        if (div_res.done) begin
          state_nxt = ST_OUT;
        end
      end
      // result strobe
      ST_OUT: begin
        ov_nxt = 1'b1;
        if (clip_r) begin
          od_nxt.gradient = neg_r ? signed'(32'd0 - {1'b0, div_res.quot})
                                  : signed'({1'b0, div_res.quot});
        end else begin
          od_nxt.gradient = signed'(g_r);
        end
        od_nxt.last = (rd_r + 1'b1 == cnt_r);
        rd_nxt      = rd_r + 1'b1;
        if (rd_r + 1'b1 == cnt_r) begin
          done_nxt = 1'b1;
        end
        clip_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    ram_wdata = gval;
  end

  // divider kicked off in ST_CDIV, once its operands are registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cdiv_go_r <= 1'b0;
    end else begin
      cdiv_go_r <= (state_r == ST_CST);
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    ent_r     <= ent_nxt;
    xq_r      <= xq_nxt;
    ymp_r     <= ymp_nxt;
    pq_r      <= pq_nxt;
    den_r     <= den_nxt;
    absdiff_r <= absdiff_nxt;
    dneg_r    <= dneg_nxt;
    prod_r    <= prod_nxt;
    num_r     <= num_nxt;
    sat_r     <= sat_nxt;
    neg_r     <= neg_nxt;
    g_r       <= g_nxt;
    od_r      <= od_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clip_r  <= 1'b0;
      cnt_r   <= '0;
      rd_r    <= '0;
      max_r   <= '0;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clip_r  <= clip_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= rd_nxt;
      max_r   <= max_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

### hdl/bce_gradient_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_gradient_clip
// Binary cross-entropy gradient with global clipping, Q16.16 fixed point.
//
//   Channel   Ports                          Transaction
//   input     start, busy, in_data           load element or read request
//   result    out_valid, out_data            one clipped gradient, one cycle
//   config    cfg_valid, cfg_ready,          batch_count (0), clip_limit (1)
//             cfg_index, cfg_data
//
// A load holds the back end through the multiply, check, divide and store
// states, skipping the divider when the quotient saturates; a read holds it
// to the result, using the shared 31-step divider when clipping applies.
// The front stage and a two-entry queue take further transactions while the
// back end works; busy is high while both are full.
// Synchronous active-low reset; the store itself is not cleared.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module bce_gradient_clip (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bgc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  output bgc_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);

  logic              push, pop;
  bgc_pkg::fe_item_t push_data, head;
  bgc_pkg::q_stat_t  q_stat;
  logic [15:0]       batch_r;
  logic [30:0]       clip_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= 16'd1;
      clip_r  <= 31'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bgc_pkg::CFG_BATCH_COUNT: batch_r <= cfg_data[15:0];
        bgc_pkg::CFG_CLIP_LIMIT:  clip_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  bgc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  bgc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  bgc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .head        (head),
    .pop         (pop),
    .batch_count (batch_r),
    .clip_limit  (clip_r),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

### hdl/bgc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_port_checks
// Port level checks on the gradient clipping block.
// ----------------------------------------------------------------------------
module bgc_port_checks (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);

  // nothing held after reset
  a_busy_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  // a read passes through the idle and read states before its strobe, so strobes never follow each other
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  // busy only rises when a transaction has just been taken
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transaction");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind bce_gradient_clip bgc_port_checks u_bgc_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_ready (cfg_ready)
);

### tb/sv/bgc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_checker
// Watches the input, result and config channels of bce_gradient_clip, keeps
// its own model of the gradient store and clipping state, and compares every
// strobed result with the oldest predicted gradient.
// ----------------------------------------------------------------------------
module bgc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  bgc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  bgc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 grads_waiting,
  output int                 loads_seen,
  output int                 reads_seen,
  output int                 clipped_seen
);

  // model configuration
  logic [15:0] n_batch;
  logic [30:0] clip_lim;

  // model state
  logic [31:0] grad_mem [bgc_pkg::STORE_DEPTH];
  int          n_stored;
  int          rd_ptr;
  logic [31:0] peak_mag;
  logic        batch_closed;

  bgc_pkg::out_item_t grad_fifo [$];

  function automatic logic [31:0] saturate(input logic neg, input logic [127:0] mag);
    if (neg) return (mag >= 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
    return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // gradient of one element, one exact division
  function automatic logic [31:0] bce_grad(input logic [15:0] lbl, input logic [15:0] pr,
                                           input logic [31:0] w);
    longint      x, p, q, d;
    logic [127:0] ad, aw, den, quo;
    logic        dneg, wneg;
    x = lbl;
    p = pr;
    q = 32768 - longint'(pr);
    if (p < 328) p = 328;
    if (q < 328) q = 328;
    d = x * q - (32768 - x) * p;
    dneg = d < 0;
    ad = dneg ? -d : d;
    wneg = w[31];
    aw = wneg ? {96'd0, 32'd0 - w} : {96'd0, w};
    den = 128'(p) * 128'(q) * 128'((n_batch == 0) ? 16'd1 : n_batch);
    quo = (aw * ad) / den;
    return saturate(!(wneg ^ dneg), quo);
  endfunction

  task automatic predict(input bgc_pkg::in_item_t it);
    logic [31:0] g, m;
    logic [127:0] s;
    bgc_pkg::out_item_t r;
    if (it.cmd == bgc_pkg::CMD_LOAD) begin
      loads_seen++;
      if (batch_closed) begin
        n_stored = 0; rd_ptr = 0; peak_mag = 0; batch_closed = 0;
      end
      if (n_stored < bgc_pkg::STORE_DEPTH) begin
        g = bce_grad(it.label, it.prob, it.weight);
        grad_mem[n_stored] = g;
        n_stored++;
        m = g[31] ? 32'd0 - g : g;
        if (m > peak_mag) peak_mag = m;
      end
    end else begin
      reads_seen++;
      if (rd_ptr < n_stored) begin
        g = grad_mem[rd_ptr];
        if (clip_lim != 0 && peak_mag > {1'b0, clip_lim}) begin
          clipped_seen++;
          m = g[31] ? 32'd0 - g : g;
          s = (128'(m) * 128'(clip_lim)) / 128'(peak_mag);
          g = saturate(g[31], s);
        end
        r.gradient = g;
        r.last = (rd_ptr + 1 == n_stored);
        rd_ptr++;
        if (r.last) batch_closed = 1;
        grad_fifo.insert(grad_fifo.size(), r);
      end
    end
  endtask

  always @(posedge clk) begin
    bgc_pkg::out_item_t e;
    if (!rst_n) begin
      n_batch <= 16'd1; clip_lim <= '0;
      n_stored = 0; rd_ptr = 0; peak_mag = 0; batch_closed = 0;
      fail_count = 0; loads_seen = 0; reads_seen = 0; clipped_seen = 0;
      grad_fifo.delete();
    end else begin
      // config write
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bgc_pkg::CFG_BATCH_COUNT) n_batch <= cfg_data[15:0];
        else if (cfg_index == bgc_pkg::CFG_CLIP_LIMIT) clip_lim <= cfg_data[30:0];
      end
      // result check against oldest prediction
      if (out_valid) begin
        if (grad_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: unexpected result gradient=%h last=%b",
                     out_data.gradient, out_data.last);
        end else begin
          e = grad_fifo.pop_front();
          if (e.gradient !== out_data.gradient || e.last !== out_data.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected gradient=%h last=%b, got gradient=%h last=%b",
                       e.gradient, e.last, out_data.gradient, out_data.last);
          end
        end
      end
      // input transaction
      if (start && !busy) predict(in_data);
    end
    grads_waiting = grad_fifo.size();
  end

  // leftover predictions are reported by the top through grads_waiting
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for bce_gradient_clip: directed corner loads and reads,
// then random batches under several register settings, with random gaps on
// the start side. Checking is done by bgc_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SETTLE   = 250;
  localparam int WDOG_MAX = 6000;
  localparam int N_RANDOM = 1430;
  localparam int CFG_SPAN = 240;

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  bgc_pkg::in_item_t  in_data;
  bgc_pkg::out_item_t out_data;
  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, grads_waiting, loads_seen, reads_seen, clipped_seen;
  int sent, idle_cycles;
  logic no_gaps;

  bce_gradient_clip u_dut (.*);
  bgc_checker u_chk (.*);

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("status: fail");
      $finish;
    end
  end

  // one input transaction, with an optional gap after it
  task automatic send(input bgc_pkg::in_item_t it);
    start <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sent++;
    if (!no_gaps && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic bgc_pkg::in_item_t mk_load(input logic [15:0] l,
                                                input logic [15:0] p,
                                                input logic [31:0] w);
    bgc_pkg::in_item_t it;
    it.cmd = bgc_pkg::CMD_LOAD; it.label = l; it.prob = p; it.weight = w;
    return it;
  endfunction

  // any item at all, every field random
  function automatic bgc_pkg::in_item_t rnd_item();
    bgc_pkg::in_item_t it;
    it.cmd    = 1'($urandom);
    it.label  = 16'($urandom);
    it.prob   = 16'($urandom);
    it.weight = $urandom;
    return it;
  endfunction

  function automatic bgc_pkg::in_item_t mk_read();
    bgc_pkg::in_item_t it;
    it = rnd_item();
    it.cmd = bgc_pkg::CMD_READ;
    return it;
  endfunction

  function automatic bgc_pkg::in_item_t rnd_load();
    logic [15:0] l, p;
    logic [31:0] w;
    l = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    case ($urandom_range(7))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = $urandom;
      default: w = 32'($signed($urandom_range(262144)) - 131072);
    endcase
    return mk_load(l, p, w);
  endfunction

  // register write once everything in flight has drained
  task automatic cfg_write(input logic [bgc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (grads_waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int k, cfg_mark, cfg_phase;
    logic [15:0] probs [6];
    start = 1'b0; in_data = '0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    rst_n = 1'b0; sent = 0; no_gaps = 1'b0;
    probs = '{16'd0, 16'd327, 16'd328, 16'd32441, 16'd32768, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes at reset settings, read on empty store first
    send(mk_read());
    for (int i = 0; i < 6; i++)
      send(mk_load((i % 2) ? 16'd32768 : 16'd0, probs[i],
                   (i < 3) ? 32'h7FFF_FFFF : 32'h8000_0000));
    send(mk_load(16'hFFFF, 16'd16384, 32'hFFFF_FFFF));
    send(mk_load(16'd16384, 16'd16384, 32'd0));
    for (int i = 0; i < 9; i++) send(mk_read());   // one past the end
    send(mk_load(16'd100, 16'd30000, 32'h0001_0000)); // new batch
    send(mk_read());

    // random batches, settings changed every few hundred items
    k = 0; cfg_mark = 0; cfg_phase = 0;
    while (k < N_RANDOM) begin
      if (k >= cfg_mark) begin
        case (cfg_phase % 6)
          0: begin
            cfg_write(bgc_pkg::CFG_BATCH_COUNT, 32'd1);
            cfg_write(bgc_pkg::CFG_CLIP_LIMIT, 32'd1);
          end
          1: begin
            cfg_write(bgc_pkg::CFG_BATCH_COUNT, 32'd0);
            cfg_write(bgc_pkg::CFG_CLIP_LIMIT, 32'd0);
          end
          2: begin
            cfg_write(bgc_pkg::CFG_BATCH_COUNT, $urandom_range(2, 64));
            cfg_write(bgc_pkg::CFG_CLIP_LIMIT, $urandom_range(1, 32'h0004_0000));
          end
          3: begin
            cfg_write(bgc_pkg::CFG_BATCH_COUNT, 32'hFFFF_0000 | $urandom);
            cfg_write(bgc_pkg::CFG_CLIP_LIMIT, $urandom);
          end
          4: begin
            cfg_write(bgc_pkg::CFG_BATCH_COUNT, 32'd65535);
            cfg_write(bgc_pkg::CFG_CLIP_LIMIT, $urandom_range(1, 100));
          end
          default: begin
            cfg_write(bgc_pkg::CFG_BATCH_COUNT, $urandom_range(1, 8));
            cfg_write(bgc_pkg::CFG_CLIP_LIMIT,
                      32'h8000_0000 | $urandom_range(1, 32'h0100_0000));
          end
        endcase
        cfg_phase++;
        cfg_mark += CFG_SPAN;
      end
      no_gaps = (k >= 500 && k < 750);
      if ($urandom_range(9) == 0) begin
        // noise: any item at all
        send(rnd_item());
        k++;
      end else begin
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          send(rnd_load());
          k++;
          if ($urandom_range(9) == 0) begin
            send(mk_read());
            k++;
          end
        end
        n = n + $urandom_range(0, 2) - (($urandom_range(4) == 0) ? 2 : 0);
        for (int i = 0; i < n; i++) begin
          send(mk_read());
          k++;
        end
      end
    end
    start <= 1'b0;

    // drain
    @(posedge clk);
    while (grads_waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d transactions: %0d loads, %0d reads, %0d clipped gradients",
             sent, loads_seen, reads_seen, clipped_seen);
    $display("mismatches %0d, predictions left over %0d", fail_count, grads_waiting);
    if (fail_count == 0 && grads_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
